FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define WBPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WBPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/wbps_pkg.sv
`default_nettype none
package wbps_pkg;

   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int LEN_CFG_W = 6;
   localparam int WORD_BYTES = 8;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register map
   localparam csr_idx_type CSR_LEN  = 3'd0;
   localparam csr_idx_type CSR_PAT0 = 3'd1;
   localparam csr_idx_type CSR_PAT1 = 3'd2;
   localparam csr_idx_type CSR_PAT2 = 3'd3;
   localparam csr_idx_type CSR_PAT3 = 3'd4;
   localparam csr_idx_type CSR_MASK = 3'd5;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } scan_result_type;

endpackage
`default_nettype wire

FILE: rtl/wbps_cfg.sv
`default_nettype none
module wbps_cfg
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_valid,
   input  wire csr_idx_type                               csr_index,
   input  wire logic [ADDR_W-1:0]                         csr_wdata,
   output logic [LEN_W-1:0]                               len,
   output logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]       pat,
   output logic [MAX_PATTERN_BYTES-1:0]                   mask
);

   logic [LEN_W-1:0]                         len_ff, len_in;
   logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] pat_ff, pat_in;
   logic [MAX_PATTERN_BYTES-1:0]             mask_ff, mask_in;
   logic [LEN_CFG_W-1:0]                     len_wr;

   assign len_wr = csr_wdata[LEN_CFG_W-1:0];

   always_comb begin
      len_in  = len_ff;
      pat_in  = pat_ff;
      mask_in = mask_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            CSR_LEN: begin
               // zero acts as one, oversize saturates
               if (len_wr == '0) begin
                  len_in = LEN_W'(1);
               end else if (len_wr > LEN_CFG_W'(MAX_PATTERN_BYTES)) begin
                  len_in = LEN_W'(MAX_PATTERN_BYTES);
               end else begin
                  len_in = LEN_W'(len_wr);
               end
            end
            CSR_PAT0, CSR_PAT1, CSR_PAT2, CSR_PAT3: begin
               for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
                  if (csr_index == CSR_IDX_W'(int'(CSR_PAT0) + (b >> 3))) begin
                     pat_in[b] = csr_wdata[BYTE_W*(b & (WORD_BYTES-1)) +: BYTE_W];
                  end
               end
            end
            CSR_MASK: mask_in = csr_wdata[MAX_PATTERN_BYTES-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(1);
         pat_ff  <= '0;
         mask_ff <= '0;
      end else begin
         len_ff  <= len_in;
         pat_ff  <= pat_in;
         mask_ff <= mask_in;
      end
   end

   assign len  = len_ff;
   assign pat  = pat_ff;
   assign mask = mask_ff;

endmodule
`default_nettype wire

FILE: rtl/wbps_match.sv
`default_nettype none
module wbps_match
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      step,
   input  wire logic [BYTE_W-1:0]                         data_byte,
   input  wire logic [ADDR_W-1:0]                         byte_address,
   input  wire logic                                      scan_start,
   input  wire logic                                      scan_last,
   input  wire logic [LEN_W-1:0]                          len,
   input  wire logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]  pat,
   input  wire logic [MAX_PATTERN_BYTES-1:0]              mask,
   output logic                                           res_valid,
   output scan_result_type                                res
);

   localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);

   logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win_ff, win_in;
   logic [LEN_W-1:0]                         fill_ff, fill_in;
   logic                                     fin_ff, fin_in;

   logic [LEN_W-1:0]             fill_base, fill_new, sel;
   logic                         fin_base, active, hit;
   logic [MAX_PATTERN_BYTES-1:0] byte_ok;

   always_comb begin
      // start of scan drops the fill count and the done flag
      fill_base = scan_start ? '0 : fill_ff;
      fin_base  = scan_start ? 1'b0 : fin_ff;
      active    = step && !fin_base;

      // entry 0 is the newest byte
      win_in   = {win_ff[MAX_PATTERN_BYTES-2:0], data_byte};
      fill_new = (fill_base == LEN_W'(MAX_PATTERN_BYTES)) ? fill_base
                                                           : fill_base + LEN_W'(1);

      // pattern byte i lines up with window entry len-1-i
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         sel        = len - LEN_W'(1) - LEN_W'(i);
         byte_ok[i] = mask[i] || (LEN_W'(i) >= len) ||
                      (win_in[sel[IDX_W-1:0]] == pat[i]);
      end
      hit = (&byte_ok) && (fill_new >= len);

      res_valid  = active && (hit || scan_last);
      res.found  = hit;
      res.addr   = hit ? byte_address - ADDR_W'(len - LEN_W'(1)) : '0;

      win_in  = active ? win_in : win_ff;
      fill_in = active ? fill_new : (step ? fill_base : fill_ff);
      fin_in  = step ? (fin_base || res_valid) : fin_ff;
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fin_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         fin_ff  <= fin_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/wildcard_byte_pattern_scanner.sv
`default_nettype none
// Wildcard byte pattern scanner. Stream one byte per transaction on req_ with
// its address; mark the first byte of a scan with req_scan_start and the final
// byte with req_scan_last. After each byte the newest pattern_length bytes are
// compared in parallel against the programmed pattern, skipping positions whose
// wildcard bit is set. The first match gives one rsp_ transaction with
// rsp_found = 1 and the address of the first matching byte; a scan that ends
// without a match gives rsp_found = 0 and address 0. Later bytes of that scan
// are dropped until the next start. Throughput is one byte per clock: the
// whole window compare is combinational between the input register and the
// response register, so only rsp_ready backpressure slows intake.
// Registers on csr_ (always ready): 0 length (0 acts as 1, clamps to
// MAX_PATTERN_BYTES), 1..4 pattern bytes 0-7, 8-15, 16-23, 24-31 (byte 0 in
// the low bits), 5 wildcard mask. Write them only while no scan byte is in
// flight.
module wildcard_byte_pattern_scanner
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // byte stream
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic [ADDR_W-1:0] req_byte_address,
   input  wire logic              req_scan_start,
   input  wire logic              req_scan_last,
   // scan result
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_found,
   output logic [ADDR_W-1:0]      rsp_match_address,
   // register writes
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire csr_idx_type       csr_index,
   input  wire logic [ADDR_W-1:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

   // config
   logic [LEN_W-1:0]                         len;
   logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] pat;
   logic [MAX_PATTERN_BYTES-1:0]             mask;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_data_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic              in_start_ff, in_last_ff;

   // response register
   logic              rsp_vld_ff, rsp_vld_in;
   scan_result_type   rsp_ff, rsp_in;

   logic            accept, out_free, step, res_valid;
   scan_result_type res;

   assign csr_ready = 1'b1;

   wbps_cfg #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .LEN_W             (LEN_W)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .len       (len),
      .pat       (pat),
      .mask      (mask)
   );

   // The input stage moves on whenever the response slot is free or being
   // drained this cycle, so intake stalls only while a response waits on
   // rsp_ready.
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign step      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign accept    = req_valid && req_ready;

   wbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .LEN_W             (LEN_W)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_data_ff),
      .byte_address (in_addr_ff),
      .scan_start   (in_start_ff),
      .scan_last    (in_last_ff),
      .len          (len),
      .pat          (pat),
      .mask         (mask),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_comb begin
      in_vld_in = accept ? 1'b1 : (step ? 1'b0 : in_vld_ff);
      // res_valid only fires with step, i.e. when the slot is free
      if (res_valid) begin
         rsp_vld_in = 1'b1;
         rsp_in     = res;
      end else begin
         rsp_vld_in = rsp_vld_ff && !rsp_ready;
         rsp_in     = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff  <= req_data_byte;
         in_addr_ff  <= req_byte_address;
         in_start_ff <= req_scan_start;
         in_last_ff  <= req_scan_last;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_match_address = rsp_ff.addr;

endmodule
`default_nettype wire

FILE: rtl/wbps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module wbps_checker
   import wbps_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_found,
   input wire logic [ADDR_W-1:0] rsp_match_address
);

   `WBPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_address), "response changed while stalled")
   `WBPS_ASSERT(a_miss_addr_zero, rsp_valid && !rsp_found |-> rsp_match_address == '0, "not-found response with nonzero address")
   `WBPS_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response valid right after reset")
   `WBPS_ASSERT(a_intake_free, !rsp_valid |-> req_ready, "input stalled with empty response slot")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
`default_nettype wire
